// File: rtl/lsbse_pkg.sv
// Shared types and constants of the LSB steganography extractor.
package lsbse_pkg;

	localparam int MagicMaxDefault = 8;
	localparam logic [7:0] HeaderBytesReset = 8'd54;
	localparam int LenWidth = 32;
	localparam int CharWidth = 8;

	// Configuration register indexes
	localparam logic [1:0] REG_HEADER_BYTES = 2'd0;
	localparam logic [1:0] REG_MAGIC_TEXT = 2'd1;
	localparam logic [1:0] REG_MAGIC_LENGTH = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_BYTE = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_EARLY_END = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic PART_EXT = 1'b0;
	localparam logic PART_DATA = 1'b1;

	typedef enum logic [7:0] {
		PH_HEADER  = 8'b0000_0001,
		PH_MAGLEN  = 8'b0000_0010,
		PH_MAGIC   = 8'b0000_0100,
		PH_EXTLEN  = 8'b0000_1000,
		PH_EXT     = 8'b0001_0000,
		PH_DATALEN = 8'b0010_0000,
		PH_DATA    = 8'b0100_0000,
		PH_DONE    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       part;
		logic [1:0] status;
		logic       last;
	} result_t;

	// Negative lengths count as zero
	function automatic logic [LenWidth-1:0] clamp_len(input logic [LenWidth-1:0] v);
		clamp_len = v[LenWidth-1] ? '0 : v;
	endfunction

endpackage

// File: rtl/lsb_stego_extractor.sv
// Top level of the LSB steganography extractor: config registers, input and result stages.
//
// Decodes a hidden stream from bit 0 of each image byte after a configurable header:
// magic length and characters (checked against magic_text/magic_length), extension
// length and bytes, data length and bytes. One image byte is taken per cycle; a beat
// is held in the input register while the next-state logic decodes it, and its
// result, if any, is then registered in the output register that drives m_axis. The
// rate is one beat per cycle as long as m_axis_tready is high; a held output beat
// stalls the input side. Output tuser bit 0 is part (0 extension, 1 data), bits 2:1
// are status (0 byte, 1 magic mismatch, 2 image ended early, 3 no data); tlast marks
// the final result of an image. Bytes after the final result are dropped until tuser
// (start of image) is seen. Write configuration only while the block is idle.
module lsb_stego_extractor #(
	parameter int MAGIC_MAX = lsbse_pkg::MagicMaxDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_byte
	input  logic        s_axis_tuser,   // [0] start_of_image
	input  logic        s_axis_tlast,   // end_of_image
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [2:0]  m_axis_tuser,   // [0] part, [2:1] status
	output logic        m_axis_tlast,   // is_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [7:0]             header_bytes_q;
	logic [MAGIC_MAX*8-1:0] magic_text_q;
	logic [3:0]             magic_length_q;
	logic [3:0]             eff_mlen;

	logic valid_s1, bit_s1, sof_s1, eof_s1;
	logic adv, consume;
	lsbse_pkg::result_t result;
	lsbse_pkg::result_t out_q;
	logic out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_bytes_q <= lsbse_pkg::HeaderBytesReset;
			magic_text_q <= '0;
			magic_length_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lsbse_pkg::REG_HEADER_BYTES: header_bytes_q <= cfg_data[7:0];
				lsbse_pkg::REG_MAGIC_TEXT:   magic_text_q <= cfg_data[MAGIC_MAX*8-1:0];
				lsbse_pkg::REG_MAGIC_LENGTH: magic_length_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign eff_mlen = (magic_length_q > 4'(MAGIC_MAX)) ? 4'(MAGIC_MAX) : magic_length_q;

	// Advance when the result slot is free or being drained this cycle
	assign adv = !out_valid_q || m_axis_tready;
	assign consume = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			bit_s1 <= s_axis_tdata[0];
			sof_s1 <= s_axis_tuser;
			eof_s1 <= s_axis_tlast;
		end
	end

	lsbse_decoder #(
		.MAGIC_MAX(MAGIC_MAX)
	) u_decoder (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (consume),
		.pix_bit      (bit_s1),
		.sof          (sof_s1),
		.eof          (eof_s1),
		.header_bytes (header_bytes_q),
		.magic_text   (magic_text_q),
		.eff_mlen     (eff_mlen),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && result.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && result.emit) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q.data;
	assign m_axis_tuser = {out_q.status, out_q.part};
	assign m_axis_tlast = out_q.last;

endmodule

// File: rtl/lsbse_decoder.sv
// Decoding state and per-beat next-state logic of the extractor.
module lsbse_decoder #(
	parameter int MAGIC_MAX = lsbse_pkg::MagicMaxDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   pix_bit,
	input  logic                   sof,
	input  logic                   eof,
	input  logic [7:0]             header_bytes,
	input  logic [MAGIC_MAX*8-1:0] magic_text,
	input  logic [3:0]             eff_mlen,
	output lsbse_pkg::result_t     result
);

	lsbse_pkg::phase_t phase_q, phase_d;
	logic [7:0]  header_left_q, header_left_d;
	logic [4:0]  bit_index_q, bit_index_d;
	logic [31:0] shift_word_q, shift_word_d;
	logic [31:0] items_left_q, items_left_d;
	logic [3:0]  magic_index_q, magic_index_d;
	logic        magic_good_q, magic_good_d;

	always_comb begin
		logic        used;
		logic        wide;
		logic [31:0] v;
		logic [31:0] len;
		logic [7:0]  exp_char;

		phase_d = phase_q;
		header_left_d = header_left_q;
		bit_index_d = bit_index_q;
		shift_word_d = shift_word_q;
		items_left_d = items_left_q;
		magic_index_d = magic_index_q;
		magic_good_d = magic_good_q;
		result = '0;
		used = 1'b0;
		v = '0;
		len = '0;
		exp_char = '0;

		if (sof) begin
			phase_d = lsbse_pkg::PH_HEADER;
			header_left_d = header_bytes;
			bit_index_d = '0;
			shift_word_d = '0;
			items_left_d = '0;
			magic_index_d = '0;
			magic_good_d = 1'b1;
		end

		if (phase_d == lsbse_pkg::PH_HEADER) begin
			if (header_left_d != 8'd0) begin
				header_left_d = header_left_d - 8'd1;
				used = 1'b1;
			end else begin
				phase_d = lsbse_pkg::PH_MAGLEN;
				bit_index_d = '0;
				shift_word_d = '0;
			end
		end

		if (!used && phase_d != lsbse_pkg::PH_HEADER && phase_d != lsbse_pkg::PH_DONE) begin
			wide = (phase_d == lsbse_pkg::PH_MAGLEN) || (phase_d == lsbse_pkg::PH_EXTLEN) ||
				(phase_d == lsbse_pkg::PH_DATALEN);
			// Shift in from the top: an 8-bit item ends up in the upper byte
			shift_word_d = {pix_bit, shift_word_d[31:1]};
			if ((wide && bit_index_d == 5'd31) || (!wide && bit_index_d == 5'd7)) begin
				v = wide ? shift_word_d : {24'd0, shift_word_d[31:24]};
				len = lsbse_pkg::clamp_len(v);
				bit_index_d = '0;
				shift_word_d = '0;
				case (phase_d)
					lsbse_pkg::PH_MAGLEN: begin
						items_left_d = len;
						magic_index_d = '0;
						magic_good_d = (len == {28'd0, eff_mlen});
						phase_d = lsbse_pkg::PH_MAGIC;
						if (len == 32'd0) begin
							if (magic_good_d) begin
								phase_d = lsbse_pkg::PH_EXTLEN;
							end else begin
								result = '{1'b1, 8'd0, lsbse_pkg::PART_EXT, lsbse_pkg::ST_MISMATCH, 1'b1};
								phase_d = lsbse_pkg::PH_DONE;
							end
						end
					end
					lsbse_pkg::PH_MAGIC: begin
						for (int k = 0; k < MAGIC_MAX; k++) begin
							if (magic_index_d == 4'(k)) begin
								exp_char = magic_text[k*8 +: 8];
							end
						end
						if (magic_good_d && magic_index_d < eff_mlen && exp_char != v[7:0]) begin
							magic_good_d = 1'b0;
						end
						if (magic_index_d != 4'd15) begin
							magic_index_d = magic_index_d + 4'd1;
						end
						items_left_d = items_left_d - 32'd1;
						if (items_left_d == 32'd0) begin
							if (magic_good_d) begin
								phase_d = lsbse_pkg::PH_EXTLEN;
							end else begin
								result = '{1'b1, 8'd0, lsbse_pkg::PART_EXT, lsbse_pkg::ST_MISMATCH, 1'b1};
								phase_d = lsbse_pkg::PH_DONE;
							end
						end
					end
					lsbse_pkg::PH_EXTLEN: begin
						items_left_d = len;
						phase_d = (len == 32'd0) ? lsbse_pkg::PH_DATALEN : lsbse_pkg::PH_EXT;
					end
					lsbse_pkg::PH_EXT: begin
						result = '{1'b1, v[7:0], lsbse_pkg::PART_EXT, lsbse_pkg::ST_BYTE, 1'b0};
						items_left_d = items_left_d - 32'd1;
						if (items_left_d == 32'd0) begin
							phase_d = lsbse_pkg::PH_DATALEN;
						end
					end
					lsbse_pkg::PH_DATALEN: begin
						items_left_d = len;
						if (len == 32'd0) begin
							result = '{1'b1, 8'd0, lsbse_pkg::PART_EXT, lsbse_pkg::ST_EMPTY, 1'b1};
							phase_d = lsbse_pkg::PH_DONE;
						end else begin
							phase_d = lsbse_pkg::PH_DATA;
						end
					end
					lsbse_pkg::PH_DATA: begin
						items_left_d = items_left_d - 32'd1;
						result = '{1'b1, v[7:0], lsbse_pkg::PART_DATA, lsbse_pkg::ST_BYTE,
							items_left_d == 32'd0};
						if (items_left_d == 32'd0) begin
							phase_d = lsbse_pkg::PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end else begin
				bit_index_d = bit_index_d + 5'd1;
			end
		end

		// Early end overrides any byte completed on the same beat
		if (eof && phase_d != lsbse_pkg::PH_DONE) begin
			result = '{1'b1, 8'd0, lsbse_pkg::PART_EXT, lsbse_pkg::ST_EARLY_END, 1'b1};
			phase_d = lsbse_pkg::PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lsbse_pkg::PH_HEADER;
			header_left_q <= '0;
			bit_index_q <= '0;
			shift_word_q <= '0;
			items_left_q <= '0;
			magic_index_q <= '0;
			magic_good_q <= 1'b1;
		end else if (step) begin
			phase_q <= phase_d;
			header_left_q <= header_left_d;
			bit_index_q <= bit_index_d;
			shift_word_q <= shift_word_d;
			items_left_q <= items_left_d;
			magic_index_q <= magic_index_d;
			magic_good_q <= magic_good_d;
		end
	end

endmodule
